>>> sv/binary_trie_prefix_counter_defines.svh
// assertion macros for the trie counter top level
`ifndef BINARY_TRIE_PREFIX_COUNTER_DEFINES_SVH
`define BINARY_TRIE_PREFIX_COUNTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BTPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btpc same-cycle check failed");

// next-cycle implication, checked out of reset
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btpc next-cycle check failed");

`endif

>>> sv/btpc_pkg.sv
// constants and codes for the binary trie prefix counter
package btpc_pkg;

    localparam int NODE_POOL_DEF    = 4096;
    localparam int MAX_KEY_BITS_DEF = 64;

    localparam int KEY_W = 64;
    localparam int LEN_W = 7;
    localparam int CNT_W = 32;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

endpackage

>>> sv/btpc_node_mem.sv
// node memory: one write port, one read port with registered read data
module btpc_node_mem #(
    parameter int DEPTH  = btpc_pkg::NODE_POOL_DEF,
    parameter int ADDR_W = $clog2(btpc_pkg::NODE_POOL_DEF),
    parameter int DATA_W = btpc_pkg::CNT_W + 2 * $clog2(btpc_pkg::NODE_POOL_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/binary_trie_prefix_counter.sv
// top level: trie walk sequencer around the shared count adder and node memory
//
//  channel | valid   | ready   | word fields
//  --------+---------+---------+------------------------------------------
//  in      | i_valid | o_ready | i_command, i_key, i_key_len, i_amount
//  out     | o_valid | i_ready | o_count, o_status
//
// an item runs from its accept in idle through one walk step per trie level (up to
// min(key_len, MAX_KEY_BITS) levels) plus one for the end node, then a done state
// holding the result until it is taken, before the next accept. a get that
// misses a child or an add that runs out of pool ends the walk early. the node memory
// read-modify-write (one level per cycle, next node read while the current one is
// written) paces the walk. reset clears the sequencer, pool pointer and root flag;
// the node memory needs no clearing pass. a stalled result holds the block off input.
`include "binary_trie_prefix_counter_defines.svh"

module binary_trie_prefix_counter #(
    parameter int NODE_POOL    = btpc_pkg::NODE_POOL_DEF,
    parameter int MAX_KEY_BITS = btpc_pkg::MAX_KEY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic [btpc_pkg::KEY_W-1:0]       i_key,
    input  logic [btpc_pkg::LEN_W-1:0]       i_key_len,
    input  logic signed [btpc_pkg::CNT_W-1:0] i_amount,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [btpc_pkg::CNT_W-1:0] o_count,
    output logic                             o_status
);

    localparam int IDX_W   = $clog2(NODE_POOL);
    localparam int NF_W    = $clog2(NODE_POOL + 1);
    localparam int REM_W   = $clog2(MAX_KEY_BITS + 1);
    localparam int CNT_W   = btpc_pkg::CNT_W;
    localparam int ENTRY_W = CNT_W + 2 * IDX_W;
    localparam logic [NF_W-1:0] POOL_N = NF_W'(NODE_POOL);
    localparam logic [btpc_pkg::LEN_W-1:0] MAX_LEN = btpc_pkg::LEN_W'(MAX_KEY_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_node, n_node;
    logic                       r_fresh, n_fresh;
    logic [btpc_pkg::KEY_W-1:0] r_key, n_key;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic                       r_cmd, n_cmd;
    logic [CNT_W-1:0]           r_amt, n_amt;
    logic [NF_W-1:0]            r_next_free, n_next_free;
    logic                       r_root_ok;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_status, n_status;

    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr, w_raddr;
    logic [ENTRY_W-1:0]         w_wdata, w_rdata, w_cur;
    logic [IDX_W-1:0]           w_left, w_right, w_child, w_new;
    logic [IDX_W-1:0]           w_left_n, w_right_n;
    logic [CNT_W-1:0]           w_cnt, w_sum;
    logic                       w_dir, w_more, w_full, w_alloc;
    logic [btpc_pkg::LEN_W-1:0] w_len_sat;

    btpc_node_mem #(
        .DEPTH  (NODE_POOL),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // a node just taken from the pool, or the root before its first write, reads as empty
    assign w_cur   = (r_fresh || (r_node == '0 && !r_root_ok)) ? '0 : w_rdata;
    assign w_left  = w_cur[ENTRY_W-1 -: IDX_W];
    assign w_right = w_cur[CNT_W +: IDX_W];
    assign w_cnt   = w_cur[CNT_W-1:0];
    assign w_dir   = r_key[0];
    assign w_child = w_dir ? w_right : w_left;
    assign w_more  = (r_rem != '0);
    assign w_full  = (r_next_free == POOL_N);
    assign w_new   = r_next_free[IDX_W-1:0];
    assign w_sum   = w_cnt + r_amt;
    assign w_alloc = (r_cmd == btpc_pkg::CMD_ADD) && w_more && (w_child == '0) && !w_full;

    assign w_left_n  = (w_alloc && !w_dir) ? w_new : w_left;
    assign w_right_n = (w_alloc && w_dir) ? w_new : w_right;
    assign w_wdata   = {w_left_n, w_right_n, w_sum};
    assign w_waddr   = r_node;
    assign w_len_sat = (i_key_len > MAX_LEN) ? MAX_LEN : i_key_len;

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_fresh     = r_fresh;
        n_key       = r_key;
        n_rem       = r_rem;
        n_cmd       = r_cmd;
        n_amt       = r_amt;
        n_next_free = r_next_free;
        n_count     = r_count;
        n_status    = r_status;
        w_we        = 1'b0;
        w_raddr     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_node  = '0;
                    n_fresh = 1'b0;
                    n_key   = i_key;
                    n_rem   = REM_W'(w_len_sat);
                    n_cmd   = i_command;
                    n_amt   = CNT_W'(i_amount);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_key = r_key >> 1;
                n_rem = r_rem - REM_W'(1);
                if (r_cmd == btpc_pkg::CMD_ADD) begin
                    w_we = 1'b1;
                    if (!w_more) begin
                        n_count  = '0;
                        n_status = btpc_pkg::ST_OK;
                        n_state  = S_DONE;
                    end else if (w_child != '0) begin
                        n_node  = w_child;
                        n_fresh = 1'b0;
                        w_raddr = w_child;
                    end else if (w_full) begin
                        // pool exhausted: this node keeps the amount, the walk stops
                        n_count  = '0;
                        n_status = btpc_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_node      = w_new;
                        n_fresh     = 1'b1;
                        n_next_free = r_next_free + NF_W'(1);
                    end
                end else begin
                    if (!w_more) begin
                        n_count  = w_cnt;
                        n_status = btpc_pkg::ST_OK;
                        n_state  = S_DONE;
                    end else if (w_child == '0) begin
                        n_count  = '0;
                        n_status = btpc_pkg::ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_node  = w_child;
                        n_fresh = 1'b0;
                        w_raddr = w_child;
                    end
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= NF_W'(1);
            r_root_ok   <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_fresh     <= n_fresh;
            if (w_we && w_waddr == '0) begin
                r_root_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_key    <= n_key;
        r_rem    <= n_rem;
        r_cmd    <= n_cmd;
        r_amt    <= n_amt;
        r_count  <= n_count;
        r_status <= n_status;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_count  = $signed(r_count);
    assign o_status = r_status;

    `BTPC_ASSERT_NOW(a_pool_bound, 1'b1, r_next_free <= POOL_N)
    `BTPC_ASSERT_NOW(a_full_only_add, o_valid && o_status, r_cmd == btpc_pkg::CMD_ADD)
    `BTPC_ASSERT_NOW(a_get_no_write, r_state == S_WALK && r_cmd == btpc_pkg::CMD_GET, !w_we)
    `BTPC_ASSERT_NEXT(a_accept_walks, i_valid && o_ready, r_state == S_WALK && r_node == '0)
    `BTPC_ASSERT_NEXT(a_alloc_fresh, r_state == S_WALK && w_alloc, r_fresh && r_node == $past(w_new))

endmodule
